@@ rtl/uft_pkg.sv @@
`timescale 1ns / 1ps
package uft_pkg;
  localparam int unsigned OpW = 2;
  localparam int unsigned IdxW = 10;
  localparam int unsigned CntW = 11;
  localparam logic [CntW-1:0] CountReset = 11'd1024;

  typedef enum logic [1:0] {
    OP_FIND  = 2'd0,
    OP_SIZE  = 2'd1,
    OP_MERGE = 2'd2,
    OP_KEEPX = 2'd3
  } op_e;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_UPRD  = 11'b00000000100,
    S_UPCHK = 11'b00000001000,
    S_DNRD  = 11'b00000010000,
    S_DNCHK = 11'b00000100000,
    S_NEXT  = 11'b00001000000,
    S_RRD   = 11'b00010000000,
    S_RCHK  = 11'b00100000000,
    S_LINK  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_e;
endpackage

@@ rtl/union_find_table_core.sv @@
`timescale 1ns / 1ps
// Disjoint-set table with path compression and union by size (OP_KEEPX keeps x's root).
// Channels: input beat (operation_i, elem_x_i, elem_y_i) on in_valid/in_ready,
// result beat (root_index_o, set_count_o, joined_o, bad_index_o) on
// out_valid/out_ready, and a config beat carrying element_count on
// cfg_valid/cfg_ready.
// The table lives in one synchronous RAM with a registered read.
// An item walks parent links to the root, then walks again, reading each
// node in S_DNRD and rewriting it in S_DNCHK to point at the root.
// With OP_MERGE only, union by size keeps the links from an element to its
// root at most log2 of the element count; OP_KEEPX always makes x's root
// the new root, so it can exceed that bound.
// One item is in flight at a time; a flagged index answers in the cycle after
// its beat. The next input beat is taken in the cycle after the result beat.
// After reset a clearing pass writes every entry to a singleton; no input
// beat is accepted during the pass.
// The result stays in its register until taken; a stalled receiver holds
// the block, since the next item is accepted only once the result is gone.
module union_find_table_core
  import uft_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OpW-1:0]  operation_i,
  input  logic [IdxW-1:0] elem_x_i,
  input  logic [IdxW-1:0] elem_y_i,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [IdxW-1:0] root_index_o,
  output logic [CntW-1:0] set_count_o,
  output logic            joined_o,
  output logic            bad_index_o,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [CntW-1:0] cfg_data
);
  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned VW = (AW + 1 > CntW) ? AW + 1 : CntW;
  localparam int unsigned EW = VW + 1;
  localparam int unsigned LW = AW + 1;
  localparam logic [LW-1:0] MaxLim = LW'(MAX_ELEMENTS);
  localparam logic [CntW-1:0] CntMax = (MAX_ELEMENTS > 2047) ? CntW'(2047) :
                                       CntW'(MAX_ELEMENTS);

  // entry: {root flag, value}; value is size for a root, parent otherwise
  logic [EW-1:0] mem_q [MAX_ELEMENTS];
  logic [EW-1:0] rdata_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  state_e        state_q, state_d;
  logic [CntW-1:0] count_q;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] start_q, start_d;
  logic [AW-1:0] rx_q, rx_d;
  logic [AW-1:0] y_q, y_d;
  logic          second_q, second_d;
  logic [OpW-1:0] op_q, op_d;
  logic [VW-1:0] sx_q, sx_d;
  logic [LW-1:0] steps_q, steps_d;
  logic          ov_q, ov_d;
  logic [IdxW-1:0] ro_q, ro_d;
  logic [CntW-1:0] so_q, so_d;
  logic          jo_q, jo_d, bo_q, bo_d;

  logic [CntW-1:0] lim;
  logic          rroot;
  logic [VW-1:0] rval;
  logic          big;
  logic          xbad, ybad;

  assign lim   = (count_q < CntMax) ? count_q : CntMax;
  assign rroot = rdata_q[EW-1];
  assign rval  = rdata_q[VW-1:0];
  assign big   = (rval >= VW'(MAX_ELEMENTS));
  assign xbad  = (CntW'(elem_x_i) >= lim);
  assign ybad  = (CntW'(elem_y_i) >= lim);

  // table RAM
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign in_ready     = (state_q == S_IDLE) && !ov_q;
  assign cfg_ready    = 1'b1;
  assign out_valid    = ov_q;
  assign root_index_o = ro_q;
  assign set_count_o  = so_q;
  assign joined_o     = jo_q;
  assign bad_index_o  = bo_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cur_d    = cur_q;
    start_d  = start_q;
    rx_d     = rx_q;
    y_d      = y_q;
    second_d = second_q;
    op_d     = op_q;
    sx_d     = sx_q;
    steps_d  = steps_q;
    ov_d     = ov_q;
    ro_d     = ro_q;
    so_d     = so_q;
    jo_d     = jo_q;
    bo_d     = bo_q;
    we       = 1'b0;
    waddr    = cur_q;
    wdata    = '0;
    raddr    = cur_q;
    if (ov_q && out_ready) begin
      ov_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = {1'b1, VW'(1)};
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(MAX_ELEMENTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (xbad || (operation_i[1] && ybad)) begin
            ov_d = 1'b1;
            ro_d = '0;
            so_d = '0;
            jo_d = 1'b0;
            bo_d = 1'b1;
          end else begin
            op_d     = operation_i;
            cur_d    = AW'(elem_x_i);
            start_d  = AW'(elem_x_i);
            y_d      = AW'(elem_y_i);
            second_d = 1'b0;
            steps_d  = '0;
            state_d  = S_UPRD;
          end
        end
      end
      // issue read of current node on the upward walk
      S_UPRD: begin
        raddr   = cur_q;
        state_d = S_UPCHK;
      end
      S_UPCHK: begin
        if (rroot || big || steps_q == MaxLim) begin
          // cur_q is taken as the root; start compression
          rx_d    = cur_q;
          cur_d   = start_q;
          steps_d = '0;
          state_d = S_DNRD;
        end else begin
          cur_d   = AW'(rval);
          steps_d = steps_q + LW'(1);
          raddr   = AW'(rval);
          state_d = S_UPCHK;
        end
      end
      S_DNRD: begin
        raddr   = cur_q;
        state_d = S_DNCHK;
      end
      S_DNCHK: begin
        if (cur_q == rx_q || rroot || steps_q == MaxLim) begin
          state_d = S_NEXT;
        end else begin
          we      = 1'b1;
          waddr   = cur_q;
          wdata   = {1'b0, VW'(rx_q)};
          steps_d = steps_q + LW'(1);
          if (big) begin
            state_d = S_NEXT;
          end else begin
            cur_d   = AW'(rval);
            state_d = S_DNRD;
          end
        end
      end
      // a walk is done: start the y walk after the first, else read the root
      S_NEXT: begin
        if (op_q[1] && !second_q) begin
          second_d = 1'b1;
          start_d  = y_q;
          cur_d    = y_q;
          sx_d     = VW'(rx_q);
          steps_d  = '0;
          state_d  = S_UPRD;
        end else begin
          state_d = S_RRD;
          raddr   = rx_q;
        end
      end
      S_RRD: begin
        // rdata is root entry of last walk; keep its size, and for a merge read the other root
        if (op_q[1]) begin
          y_d     = rx_q;
          so_d    = CntW'(rval);
          raddr   = AW'(sx_q);
          state_d = S_RCHK;
        end else begin
          ov_d    = 1'b1;
          ro_d    = IdxW'(rx_q);
          so_d    = CntW'(rval);
          jo_d    = 1'b0;
          bo_d    = 1'b0;
          state_d = S_OUT;
        end
        sx_d = (op_q[1]) ? sx_q : VW'(rval);
        rx_d = rx_q;
        cur_d = cur_q;
        we = 1'b0;
        if (op_q[1]) begin
          sx_d = {VW{1'b0}} | VW'(rval);
          rx_d = AW'(sx_q);
        end
      end
      // rdata: x root entry; sx_q: y root size; rx_q: x root; y_q: y root
      S_RCHK: begin
        if (rx_q == y_q) begin
          ov_d = 1'b1;
          ro_d = IdxW'(rx_q);
          so_d = CntW'(rval);
          jo_d = 1'b0;
          bo_d = 1'b0;
          state_d = S_OUT;
        end else begin
          if (op_q == OP_KEEPX || rval > sx_q) begin
            we    = 1'b1;
            waddr = rx_q;
            wdata = {1'b1, rval + sx_q};
            cur_d = y_q;
            ro_d  = IdxW'(rx_q);
            so_d  = CntW'(rval + sx_q);
          end else begin
            we    = 1'b1;
            waddr = y_q;
            wdata = {1'b1, rval + sx_q};
            cur_d = rx_q;
            ro_d  = IdxW'(y_q);
            so_d  = CntW'(rval + sx_q);
          end
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        we      = 1'b1;
        waddr   = cur_q;
        wdata   = {1'b0, VW'(ro_q)};
        ov_d    = 1'b1;
        jo_d    = 1'b1;
        bo_d    = 1'b0;
        state_d = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      count_q <= CountReset;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
      if (cfg_valid && cfg_ready) begin
        count_q <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    start_q  <= start_d;
    rx_q     <= rx_d;
    y_q      <= y_d;
    second_q <= second_d;
    op_q     <= op_d;
    sx_q     <= sx_d;
    steps_q  <= steps_d;
    ro_q     <= ro_d;
    so_q     <= so_d;
    jo_q     <= jo_d;
    bo_q     <= bo_d;
  end

  // no input beat during the clearing pass
  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready)
    else $error("input accepted while clearing");
  // a flagged result carries no root or size
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && bad_index_o |-> set_count_o == '0 && !joined_o)
    else $error("flagged result not cleared");
  // a result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(root_index_o))
    else $error("result dropped under stall");
endmodule
